[rtl/core/tli_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tli_pkg
// Shared types and constants of the breakpoint table interpolator.
// ----------------------------------------------------------------------------
package tli_pkg;

   localparam int unsigned DEF_TABLE_DEPTH = 256;
   localparam logic [31:0] DEF_WRAP_PERIOD = 32'd5940;
   localparam logic [31:0] DEF_FLUX_THRESH = 32'd0;

   // Configuration register map.
   localparam int unsigned CSR_ADDR_W = 3;
   localparam logic        REG_WRAP_PERIOD = 1'b0;
   localparam logic        REG_FLUX_THRESH = 1'b1;

   // Request kinds.
   localparam logic REQ_LOAD  = 1'b0;
   localparam logic REQ_QUERY = 1'b1;

   // Response status codes.
   localparam logic [2:0] STAT_OK        = 3'd0;
   localparam logic [2:0] STAT_STORED    = 3'd1;
   localparam logic [2:0] STAT_FULL      = 3'd2;
   localparam logic [2:0] STAT_TOO_FEW   = 3'd3;
   localparam logic [2:0] STAT_EQUAL_T   = 3'd4;

   // Search token that travels down the row of table cells.
   typedef struct packed {
      logic [31:0] qtime;
      logic [31:0] prev_time;
      logic [31:0] prev_flux;
      logic [31:0] t0;
      logic [31:0] f0;
      logic [31:0] t1;
      logic [31:0] f1;
      logic        found;
   } token_type;

endpackage

[rtl/core/tli_if.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tli_req_if / tli_rsp_if
// Valid/ready channels for requests and responses of the interpolator.
// ----------------------------------------------------------------------------
interface tli_req_if;
   logic        valid;
   logic        ready;
   logic        req_type;
   logic [31:0] entry_time;
   logic [31:0] entry_flux;
   logic [31:0] query_time;

   modport source (output valid, req_type, entry_time, entry_flux, query_time,
                   input ready);
   modport sink   (input valid, req_type, entry_time, entry_flux, query_time,
                   output ready);
endinterface

interface tli_rsp_if;
   logic        valid;
   logic        ready;
   logic [31:0] flux_out;
   logic        above_threshold;
   logic [2:0]  status;

   modport source (output valid, flux_out, above_threshold, status,
                   input ready);
   modport sink   (input valid, flux_out, above_threshold, status,
                   output ready);
endinterface

[rtl/core/table_linear_interpolator.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// table_linear_interpolator
// Breakpoint table with linear interpolation, period wrap and threshold flag.
// ----------------------------------------------------------------------------
// A load request appends one breakpoint, unless the table is full, and goes
// straight to the done state. A query with two or more entries walks the
// search token down the row of TABLE_DEPTH cells one cell per cycle, after
// the shared divider has taken the query time modulo the wrap period when
// the wrap applies; unless the chosen segment has equal times, the divider
// then gives the interpolation quotient. One request is worked on at a time;
// a new request is taken while the previous response waits.
// ----------------------------------------------------------------------------
module table_linear_interpolator #(
   parameter int unsigned TABLE_DEPTH = tli_pkg::DEF_TABLE_DEPTH
) (
   input  logic                            clock,
   input  logic                            reset,
   tli_req_if.sink                         req_ch,
   tli_rsp_if.source                       rsp_ch,
   input  logic                            csr_psel,
   input  logic                            csr_penable,
   input  logic                            csr_pwrite,
   input  logic [tli_pkg::CSR_ADDR_W-1:0]  csr_paddr,
   input  logic [31:0]                     csr_pwdata,
   output logic [31:0]                     csr_prdata,
   output logic                            csr_pready
);
   import tli_pkg::*;

   localparam int unsigned CNT_W  = $clog2(TABLE_DEPTH + 1);
   localparam int unsigned SCAN_W = $clog2(TABLE_DEPTH);

   typedef enum logic [6:0] {
      ST_IDLE = 7'b0000001,
      ST_WRAP = 7'b0000010,
      ST_SCAN = 7'b0000100,
      ST_MUL  = 7'b0001000,
      ST_DIVS = 7'b0010000,
      ST_DIV  = 7'b0100000,
      ST_DONE = 7'b1000000
   } state_type;

   state_type         state_ff, state_in;
   logic [31:0]       wrap_ff, thresh_ff;
   logic [CNT_W-1:0]  count_ff;
   logic [31:0]       last_time_ff;
   logic [31:0]       qtime_ff;
   logic [SCAN_W-1:0] scan_ff;
   logic [63:0]       prod_ff;
   logic [31:0]       dd_ff, f0_ff;
   logic              neg_ff;
   logic [31:0]       res_flux_ff;
   logic              res_above_ff;
   logic [2:0]        res_stat_ff;
   logic              rsp_valid_ff;
   logic [31:0]       rsp_flux_ff;
   logic              rsp_above_ff;
   logic [2:0]        rsp_stat_ff;

   logic              accept, is_load, csr_wr, need_wrap, out_free, store;
   token_type         tok [TABLE_DEPTH+1];
   token_type         tok_last;
   logic              div_start, div_busy, div_done;
   logic [63:0]       div_dvd, div_quo;
   logic [31:0]       div_dvs, div_rem;
   logic [31:0]       dt, df, dd;
   logic              neg;
   logic [63:0]       q_rnd;
   logic [31:0]       flux;
   logic [32:0]       f0_w;

   // Configuration port.
   assign csr_pready = 1'b1;
   assign csr_wr     = csr_psel && csr_penable && csr_pwrite;
   assign csr_prdata = (csr_paddr[2] == REG_FLUX_THRESH) ? thresh_ff : wrap_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         wrap_ff   <= DEF_WRAP_PERIOD;
         thresh_ff <= DEF_FLUX_THRESH;
      end else if (csr_wr) begin
         if (csr_paddr[2] == REG_WRAP_PERIOD) begin
            wrap_ff <= csr_pwdata;
         end else begin
            thresh_ff <= csr_pwdata;
         end
      end
   end

   // Request acceptance and table append.
   assign req_ch.ready = (state_ff == ST_IDLE);
   assign accept       = req_ch.valid && req_ch.ready;
   assign is_load      = (req_ch.req_type == REQ_LOAD);
   assign store        = accept && is_load && (count_ff < CNT_W'(TABLE_DEPTH));
   assign need_wrap    = (wrap_ff != 32'd0) && (last_time_ff == wrap_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else if (store) begin
         count_ff <= count_ff + CNT_W'(1);
      end
      if (store) begin
         last_time_ff <= req_ch.entry_time;
      end
   end

   // Row of table cells; the head always takes a token holding the query time.
   always_comb begin
      tok[0]           = '0;
      tok[0].qtime     = qtime_ff;
   end

   for (genvar i = 0; i < TABLE_DEPTH; i++) begin : g_cell
      tli_cell #(.IDX(i), .CNT_W(CNT_W)) u_cell (
         .clock   (clock),
         .reset   (reset),
         .wr_en   (store),
         .wr_time (req_ch.entry_time),
         .wr_flux (req_ch.entry_flux),
         .count   (count_ff),
         .tok_in  (tok[i]),
         .tok_out (tok[i+1])
      );
   end

   assign tok_last = tok[TABLE_DEPTH];

   // Shared divider: wrap remainder from idle, interpolation quotient later.
   assign div_start = (accept && !is_load && (count_ff >= CNT_W'(2)) && need_wrap)
                      || (state_ff == ST_DIVS);
   assign div_dvd   = (state_ff == ST_IDLE) ? {32'd0, req_ch.query_time} : prod_ff;
   assign div_dvs   = (state_ff == ST_IDLE) ? wrap_ff : dd_ff;

   tli_divider u_div (
      .clock     (clock),
      .reset     (reset),
      .start     (div_start),
      .dividend  (div_dvd),
      .divisor   (div_dvs),
      .busy      (div_busy),
      .done      (div_done),
      .quotient  (div_quo),
      .remainder (div_rem)
   );

   // Signed differences of the chosen segment.
   always_comb begin
      neg = 1'b0;
      if (tok_last.qtime >= tok_last.t0) begin
         dt = tok_last.qtime - tok_last.t0;
      end else begin
         dt  = tok_last.t0 - tok_last.qtime;
         neg = ~neg;
      end
      if (tok_last.f1 >= tok_last.f0) begin
         df = tok_last.f1 - tok_last.f0;
      end else begin
         df  = tok_last.f0 - tok_last.f1;
         neg = ~neg;
      end
      if (tok_last.t1 >= tok_last.t0) begin
         dd = tok_last.t1 - tok_last.t0;
      end else begin
         dd  = tok_last.t0 - tok_last.t1;
         neg = ~neg;
      end
   end

   // Round to nearest, ties away, then saturate to the flux range.
   always_comb begin
      q_rnd = div_quo + 64'((div_rem >= (dd_ff - div_rem)) ? 1 : 0);
      f0_w  = {1'b0, f0_ff};
      if (neg_ff) begin
         flux = (q_rnd > {32'd0, f0_ff}) ? 32'd0 : (f0_ff - q_rnd[31:0]);
      end else if (q_rnd > {32'd0, ~f0_ff}) begin
         flux = '1;
      end else begin
         flux = 32'(f0_w + {1'b0, q_rnd[31:0]});
      end
   end

   // Sequencer.
   assign out_free = !rsp_valid_ff || rsp_ch.ready;

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               if (is_load || (count_ff < CNT_W'(2))) begin
                  state_in = ST_DONE;
               end else if (need_wrap) begin
                  state_in = ST_WRAP;
               end else begin
                  state_in = ST_SCAN;
               end
            end
         end
         ST_WRAP: if (div_done) state_in = ST_SCAN;
         ST_SCAN: if (scan_ff == SCAN_W'(TABLE_DEPTH - 1)) state_in = ST_MUL;
         ST_MUL: begin
            state_in = (tok_last.t1 == tok_last.t0) ? ST_DONE : ST_DIVS;
         end
         ST_DIVS: state_in = ST_DIV;
         ST_DIV:  if (div_done) state_in = ST_DONE;
         ST_DONE: if (out_free) state_in = ST_IDLE;
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         scan_ff  <= '0;
      end else begin
         state_ff <= state_in;
         scan_ff  <= (state_ff == ST_SCAN) ? scan_ff + SCAN_W'(1) : '0;
      end
   end

   // Working registers and the pending response.
   always_ff @(posedge clock) begin
      if (accept) begin
         qtime_ff     <= req_ch.query_time;
         res_flux_ff  <= '0;
         res_above_ff <= 1'b0;
         res_stat_ff  <= !is_load ? STAT_TOO_FEW : (store ? STAT_STORED : STAT_FULL);
      end
      if ((state_ff == ST_WRAP) && div_done) begin
         qtime_ff <= div_rem;
      end
      if (state_ff == ST_MUL) begin
         prod_ff     <= 64'(dt) * 64'(df);
         dd_ff       <= dd;
         f0_ff       <= tok_last.f0;
         neg_ff      <= neg;
         res_stat_ff <= STAT_EQUAL_T;
      end
      if ((state_ff == ST_DIV) && div_done) begin
         res_flux_ff  <= flux;
         res_above_ff <= flux > thresh_ff;
         res_stat_ff  <= STAT_OK;
      end
   end

   // Output register toward the response channel.
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if ((state_ff == ST_DONE) && out_free) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ch.ready) begin
         rsp_valid_ff <= 1'b0;
      end
      if ((state_ff == ST_DONE) && out_free) begin
         rsp_flux_ff  <= res_flux_ff;
         rsp_above_ff <= res_above_ff;
         rsp_stat_ff  <= res_stat_ff;
      end
   end

   assign rsp_ch.valid           = rsp_valid_ff;
   assign rsp_ch.flux_out        = rsp_flux_ff;
   assign rsp_ch.above_threshold = rsp_above_ff;
   assign rsp_ch.status          = rsp_stat_ff;

   // Checks.
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(TABLE_DEPTH))
      else $error("entry count beyond table depth");

   a_append: assert property (@(posedge clock) disable iff (reset)
      store |=> count_ff == $past(count_ff) + CNT_W'(1))
      else $error("append did not advance entry count");

   a_div_idle: assert property (@(posedge clock) disable iff (reset)
      div_start |-> !div_busy)
      else $error("divider restarted while busy");

   a_flag: assert property (@(posedge clock) disable iff (reset)
      rsp_ch.valid && rsp_ch.above_threshold |-> rsp_ch.status == STAT_OK)
      else $error("threshold flag on a non-query response");

endmodule

[rtl/core/tli_cell.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tli_cell
// One breakpoint of the table. Holds its time and flux and checks the
// search token as it passes, then hands the token on to the next cell.
// ----------------------------------------------------------------------------
module tli_cell #(
   parameter int unsigned IDX   = 0,
   parameter int unsigned CNT_W = 9
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 wr_en,
   input  logic [31:0]          wr_time,
   input  logic [31:0]          wr_flux,
   input  logic [CNT_W-1:0]     count,
   input  tli_pkg::token_type   tok_in,
   output tli_pkg::token_type   tok_out
);
   import tli_pkg::*;

   logic [31:0] time_ff;
   logic [31:0] flux_ff;
   token_type   tok_ff;
   token_type   tok_in_nxt;
   logic        hit;

   // Entry storage, written once when this slot is appended.
   always_ff @(posedge clock) begin
      if (wr_en && (count == CNT_W'(IDX))) begin
         time_ff <= wr_time;
         flux_ff <= wr_flux;
      end
   end

   // Slot one always provides the fallback pair; later slots take over
   // only for the first stored entry at or after the query time.
   always_comb begin
      tok_in_nxt           = tok_in;
      tok_in_nxt.prev_time = time_ff;
      tok_in_nxt.prev_flux = flux_ff;
      hit                  = time_ff >= tok_in.qtime;
      if (IDX == 1) begin
         tok_in_nxt.t0    = tok_in.prev_time;
         tok_in_nxt.f0    = tok_in.prev_flux;
         tok_in_nxt.t1    = time_ff;
         tok_in_nxt.f1    = flux_ff;
         tok_in_nxt.found = hit;
      end else if ((IDX > 1) && (CNT_W'(IDX) < count) && !tok_in.found && hit) begin
         tok_in_nxt.t0    = tok_in.prev_time;
         tok_in_nxt.f0    = tok_in.prev_flux;
         tok_in_nxt.t1    = time_ff;
         tok_in_nxt.f1    = flux_ff;
         tok_in_nxt.found = 1'b1;
      end
   end

   // Token register toward the neighbor.
   always_ff @(posedge clock) begin
      if (reset) begin
         tok_ff.found <= 1'b0;
      end else begin
         tok_ff.found <= tok_in_nxt.found;
      end
      tok_ff.qtime     <= tok_in_nxt.qtime;
      tok_ff.prev_time <= tok_in_nxt.prev_time;
      tok_ff.prev_flux <= tok_in_nxt.prev_flux;
      tok_ff.t0        <= tok_in_nxt.t0;
      tok_ff.f0        <= tok_in_nxt.f0;
      tok_ff.t1        <= tok_in_nxt.t1;
      tok_ff.f1        <= tok_in_nxt.f1;
   end

   assign tok_out = tok_ff;

endmodule

[rtl/core/tli_divider.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tli_divider
// Restoring divider, 64-bit dividend by 32-bit divisor, one quotient bit
// per cycle. Used for the period wrap and for the interpolation quotient.
// ----------------------------------------------------------------------------
module tli_divider (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   input  logic [63:0] dividend,
   input  logic [31:0] divisor,
   output logic        busy,
   output logic        done,
   output logic [63:0] quotient,
   output logic [31:0] remainder
);
   logic [31:0] rem_ff;
   logic [63:0] quo_ff;
   logic [31:0] dvs_ff;
   logic [5:0]  cnt_ff;
   logic        busy_ff;
   logic        done_ff;
   logic [32:0] shifted;
   logic [32:0] diff;
   logic        take;

   // One restoring step.
   always_comb begin
      shifted = {rem_ff, quo_ff[63]};
      diff    = shifted - {1'b0, dvs_ff};
      take    = shifted >= {1'b0, dvs_ff};
   end

   // Control: 64 steps after each start.
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            busy_ff <= 1'b1;
            cnt_ff  <= '1;
         end else if (busy_ff) begin
            cnt_ff <= cnt_ff - 6'd1;
            if (cnt_ff == 6'd0) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   // Datapath: the dividend shifts out as the quotient shifts in.
   always_ff @(posedge clock) begin
      if (start) begin
         rem_ff <= '0;
         quo_ff <= dividend;
         dvs_ff <= divisor;
      end else if (busy_ff) begin
         rem_ff <= take ? diff[31:0] : shifted[31:0];
         quo_ff <= {quo_ff[62:0], take};
      end
   end

   assign busy      = busy_ff;
   assign done      = done_ff;
   assign quotient  = quo_ff;
   assign remainder = rem_ff;

endmodule
